/* rtl/core/odbc_pkg.sv */
// Shared types, constants and arctangent table for the omni drive mixer.
`timescale 1ns / 1ps
package odbc_pkg;
    localparam int Q14_ONE = 16384;
    localparam int DIAG_Q14 = 11585;
    localparam logic [7:0] ESCAPE_SPEED = 8'd100;
    localparam logic [15:0] OFFSET_A = 16'd27307;
    localparam logic [15:0] OFFSET_B = 16'd5461;
    localparam logic [15:0] OFFSET_C = 16'd49152;
    localparam logic signed [63:0] GAIN_Q30 = 64'sd652032874;
    localparam int ATAN_ENTRIES = 24;

    typedef enum logic [1:0] {
        MODE_CHASE = 2'd0,
        MODE_LINE1 = 2'd1,
        MODE_LINE2 = 2'd2,
        MODE_LINE3 = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        REG_LINE_THRESHOLD = 2'd0,
        REG_GOAL_HEADING   = 2'd1,
        REG_MOTOR_POWER    = 2'd2
    } t_reg;

    typedef struct packed {
        logic [9:0] ball_front;
        logic [9:0] ball_front_right;
        logic [9:0] ball_right;
        logic [9:0] ball_back_right;
        logic [9:0] ball_back;
        logic [9:0] ball_back_left;
        logic [9:0] ball_left;
        logic [9:0] ball_front_left;
        logic [8:0] heading;
        logic [9:0] line_one;
        logic [9:0] line_two;
        logic [9:0] line_three;
    } t_in;

    typedef struct packed {
        logic [7:0] wheel_a_speed;
        logic       wheel_a_reverse;
        logic [7:0] wheel_b_speed;
        logic       wheel_b_reverse;
        logic [7:0] wheel_c_speed;
        logic       wheel_c_reverse;
        logic [1:0] drive_mode;
    } t_out;

    // Side data carried beside the CORDIC rows.
    typedef struct packed {
        logic              valid;
        logic [1:0]        mode;
        logic signed [15:0] rot;
        logic [7:0]        power;
    } t_side;

    function automatic logic signed [17:0] atan_bam(input int i);
        logic signed [17:0] t;
        unique case (i)
            0: t = 18'sd8192;  1: t = 18'sd4836;  2: t = 18'sd2555;
            3: t = 18'sd1297;  4: t = 18'sd651;   5: t = 18'sd326;
            6: t = 18'sd163;   7: t = 18'sd81;    8: t = 18'sd41;
            9: t = 18'sd20;    10: t = 18'sd10;   11: t = 18'sd5;
            12: t = 18'sd3;    13: t = 18'sd1;    14: t = 18'sd1;
            default: t = 18'sd0;
        endcase
        return t;
    endfunction
endpackage

/* rtl/core/omni_drive_ball_chase_mixer.sv */
// Top level of the omni drive mixer: front end, CORDIC cell rows and wheel mix.
`timescale 1ns / 1ps
// The block takes one sensor frame in every cycle that start is high and
// busy is low; busy is tied low, so frames may arrive back to back. Each
// frame gives exactly one result, strobed by o_done for one cycle. The
// depth is set by the two rows of CORDIC cells (one vectoring row for the
// ball angle, one rotation row for the three wheel sines) plus the input,
// angle, mix and output registers. The receiver cannot stall, so results
// must be taken when strobed. Line escape frames travel down the same
// pipeline so results keep their order. Configuration is sampled per frame
// at entry; write it only while idle.
module omni_drive_ball_chase_mixer
    import odbc_pkg::*;
#(
    parameter int SAMPLE_BITS   = 10,
    parameter int CORDIC_STAGES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_in        i_data,
    output logic       o_done,
    output t_out       o_data,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [9:0] i_cfg_data
);
    localparam int NS = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
    localparam int NV = NS + 1;  // angle register after the vector row

    logic [9:0] r_thr;
    logic [8:0] r_goal;
    logic [7:0] r_power;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= 10'd650; r_goal <= 9'd0; r_power <= 8'd100;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_LINE_THRESHOLD: r_thr <= i_cfg_data;
                REG_GOAL_HEADING:   r_goal <= i_cfg_data[8:0];
                REG_MOTOR_POWER:    r_power <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;
    logic accept;
    assign accept = start && !busy;

    // Front end: sensor weighting, escape test and rotation term.
    logic [SAMPLE_BITS-1:0] smp [8];
    assign smp[0] = SAMPLE_BITS'(i_data.ball_front);
    assign smp[1] = SAMPLE_BITS'(i_data.ball_front_right);
    assign smp[2] = SAMPLE_BITS'(i_data.ball_right);
    assign smp[3] = SAMPLE_BITS'(i_data.ball_back_right);
    assign smp[4] = SAMPLE_BITS'(i_data.ball_back);
    assign smp[5] = SAMPLE_BITS'(i_data.ball_back_left);
    assign smp[6] = SAMPLE_BITS'(i_data.ball_left);
    assign smp[7] = SAMPLE_BITS'(i_data.ball_front_left);

    logic signed [31:0] sx, sy, diag;
    logic signed [10:0] diff, wdiff;
    logic [1:0]         mode_in;

    always_comb begin
        // Axis sensors weigh 1.0, diagonals 0.7071 of the diagonal sum.
        sx = 32'(signed'({1'b0, smp[2]})) - 32'(signed'({1'b0, smp[6]}));
        sy = 32'(signed'({1'b0, smp[0]})) - 32'(signed'({1'b0, smp[4]}));
        sx = sx * Q14_ONE;
        sy = sy * Q14_ONE;
        diag = (32'(signed'({1'b0, smp[1]})) + 32'(signed'({1'b0, smp[3]}))
              - 32'(signed'({1'b0, smp[5]})) - 32'(signed'({1'b0, smp[7]}))) * DIAG_Q14;
        sx = sx + diag;
        diag = (32'(signed'({1'b0, smp[1]})) - 32'(signed'({1'b0, smp[3]}))
              - 32'(signed'({1'b0, smp[5]})) + 32'(signed'({1'b0, smp[7]}))) * DIAG_Q14;
        sy = sy + diag;
        diff = 11'(signed'({2'b0, i_data.heading})) - 11'(signed'({2'b0, r_goal}));
        if (diff > 11'sd180) wdiff = diff - 11'sd360;
        else if (diff < -11'sd180) wdiff = diff + 11'sd360;
        else wdiff = diff;
        priority if (i_data.line_one > r_thr) mode_in = MODE_LINE1;
        else if (i_data.line_two > r_thr) mode_in = MODE_LINE2;
        else if (i_data.line_three > r_thr) mode_in = MODE_LINE3;
        else mode_in = MODE_CHASE;
    end

    // Stage 0 registers: weighted vector, scaled heading error, mode and power.
    logic signed [31:0] r_sx, r_sy;
    logic signed [24:0] r_err;
    t_side r_side0;

    always_ff @(posedge i_clk) begin
        r_sx <= sx; r_sy <= sy;
        r_err <= 25'(wdiff) * 25'sd16384;
        r_side0.mode <= mode_in;
        r_side0.power <= r_power;
        r_side0.rot <= '0;
        if (!i_rst_n) r_side0.valid <= 1'b0;
        else r_side0.valid <= accept;
    end

    // Pre-rotation and scaling into the vectoring row.
    logic signed [39:0] vx [NS+1], vy [NS+1];
    logic signed [17:0] vz [NS+1];
    logic               vzero;
    always_comb begin
        vzero = (r_sx == 0) && (r_sy == 0);
        if (r_sx < 0) begin
            vx[0] = -(40'(r_sx) <<< 8); vy[0] = -(40'(r_sy) <<< 8); vz[0] = 18'sd32768;
        end else begin
            vx[0] = 40'(r_sx) <<< 8;   vy[0] = 40'(r_sy) <<< 8;   vz[0] = 18'sd0;
        end
    end

    // Rotation term: truncating division by 180 as a reciprocal multiply.
    // 2^32/180 rounded up is exact for |err| below 2^22.
    logic [23:0]        err_mag;
    logic [56:0]        quot_full;
    logic [15:0]        quot;
    logic signed [15:0] rot0;
    always_comb begin
        err_mag = (r_err < 0) ? 24'(-r_err) : 24'(r_err);
        quot_full = 57'(err_mag) * 57'd23860930;
        quot = quot_full[47:32];
        rot0 = (r_err < 0) ? -signed'(quot) : signed'(quot);
    end

    // Side data delay line beside both CORDIC rows, one tap per pipeline register.
    t_side side [NV+NS+2];
    logic  zero_d [NS+1];
    assign zero_d[0] = vzero;
    always_comb begin
        side[0] = r_side0;
        side[0].rot = rot0;
    end

    for (genvar g = 0; g < NS; g++) begin : g_vec
        odbc_vec_cell #(.STAGE(g)) u_cell (
            .i_clk(i_clk), .i_x(vx[g]), .i_y(vy[g]), .i_z(vz[g]),
            .i_on(1'b1), .o_x(vx[g+1]), .o_y(vy[g+1]), .o_z(vz[g+1]));
    end

    for (genvar g = 0; g < NV + NS + 1; g++) begin : g_side
        t_side r_s;
        always_ff @(posedge i_clk) begin
            r_s <= side[g];
            if (!i_rst_n) r_s.valid <= 1'b0;
        end
        assign side[g+1] = r_s;
    end
    for (genvar g = 0; g < NS; g++) begin : g_zero
        logic r_zz;
        always_ff @(posedge i_clk) r_zz <= zero_d[g];
        assign zero_d[g+1] = r_zz;
    end

    // Angle register and three wheel phases with quadrant folding.
    logic [15:0] r_ang;
    always_ff @(posedge i_clk) r_ang <= zero_d[NS] ? 16'd0 : vz[NS][15:0];

    logic [15:0]        phi [3];
    logic signed [33:0] rx [NS+1][3], ry [NS+1][3];
    logic signed [17:0] rz [NS+1][3];
    logic               flip [3];
    always_comb begin
        phi[0] = r_ang - OFFSET_A;
        phi[1] = r_ang - OFFSET_B;
        phi[2] = r_ang - OFFSET_C;
        for (int k = 0; k < 3; k++) begin
            flip[k] = (phi[k] >= 16'd16384) && (phi[k] < 16'd49152);
            if (flip[k]) phi[k] = phi[k] - 16'd32768;
            rx[0][k] = 34'(GAIN_Q30);
            ry[0][k] = '0;
            rz[0][k] = 18'(signed'(phi[k]));
        end
    end

    for (genvar g = 0; g < NS; g++) begin : g_rot
        odbc_rot_cell #(.STAGE(g)) u_cell (
            .i_clk(i_clk), .i_x(rx[g]), .i_y(ry[g]), .i_z(rz[g]),
            .o_x(rx[g+1]), .o_y(ry[g+1]), .o_z(rz[g+1]));
    end

    logic flip_d [NS+1][3];
    assign flip_d[0] = flip;
    for (genvar g = 0; g < NS; g++) begin : g_flip
        logic r_f [3];
        always_ff @(posedge i_clk) r_f <= flip_d[g];
        assign flip_d[g+1] = r_f;
    end

    // Round, clamp, add rotation and clamp again; register the sums.
    t_side              sd;
    logic signed [33:0] rr;
    logic signed [17:0] sn, sm [3];
    logic signed [17:0] r_sum [3];
    assign sd = side[NV+NS];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rr = (ry[NS][k] + 34'sd32768) >>> 16;
            if (rr > 34'sd16384) rr = 34'sd16384;
            if (rr < -34'sd16384) rr = -34'sd16384;
            sn = flip_d[NS][k] ? -18'(rr) : 18'(rr);
            sn = sn + 18'(sd.rot);
            if (sn > 18'sd16384) sn = 18'sd16384;
            if (sn < -18'sd16384) sn = -18'sd16384;
            sm[k] = sn;
        end
    end
    always_ff @(posedge i_clk) r_sum <= sm;

    // Final product and escape patterns into the output register.
    t_side        so;
    t_out         n_out;
    logic [22:0]  prod;
    logic [14:0]  mag;
    logic [7:0]   spd [3];
    logic         rev [3];
    assign so = side[NV+NS+1];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            mag = (r_sum[k] < 0) ? 15'(-r_sum[k]) : 15'(r_sum[k]);
            prod = 23'(so.power) * 23'(mag);
            spd[k] = prod[21:14];
            rev[k] = (r_sum[k] < 0) && (so.power != 8'd0);
        end
        n_out = '0;
        n_out.drive_mode = so.mode;
        unique case (t_mode'(so.mode))
            MODE_LINE1: begin
                n_out.wheel_a_speed = ESCAPE_SPEED;
                n_out.wheel_b_speed = ESCAPE_SPEED; n_out.wheel_b_reverse = 1'b1;
            end
            MODE_LINE2: begin
                n_out.wheel_b_speed = ESCAPE_SPEED;
                n_out.wheel_c_speed = ESCAPE_SPEED; n_out.wheel_c_reverse = 1'b1;
            end
            MODE_LINE3: begin
                n_out.wheel_a_speed = ESCAPE_SPEED; n_out.wheel_a_reverse = 1'b1;
                n_out.wheel_c_speed = ESCAPE_SPEED;
            end
            default: begin
                n_out.wheel_a_speed = spd[0]; n_out.wheel_a_reverse = rev[0];
                n_out.wheel_b_speed = spd[1]; n_out.wheel_b_reverse = rev[1];
                n_out.wheel_c_speed = spd[2]; n_out.wheel_c_reverse = rev[2];
            end
        endcase
    end

    t_out r_out;
    logic r_done;
    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (!i_rst_n) r_done <= 1'b0;
        else r_done <= so.valid;
    end
    assign o_done = r_done;
    assign o_data = r_out;

    a_no_busy: assert property (@(posedge i_clk) !busy)
        else $error("busy must stay low");
    a_escape_pattern: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_data.drive_mode == MODE_LINE1 |->
            o_data.wheel_a_speed == ESCAPE_SPEED && o_data.wheel_b_reverse)
        else $error("escape pattern one wrong");
    a_zero_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_data.drive_mode != MODE_CHASE && o_data.wheel_a_speed == 8'd0
            |-> !o_data.wheel_a_reverse)
        else $error("stopped escape wheel marked reverse");
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(so.valid))
        else $error("result strobe without frame");
endmodule

/* rtl/core/odbc_vec_cell.sv */
// One vectoring CORDIC cell: a micro-rotation toward the x axis, registered.
`timescale 1ns / 1ps
module odbc_vec_cell
    import odbc_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  logic               i_clk,
    input  logic signed [39:0] i_x,
    input  logic signed [39:0] i_y,
    input  logic signed [17:0] i_z,
    input  logic               i_on,
    output logic signed [39:0] o_x,
    output logic signed [39:0] o_y,
    output logic signed [17:0] o_z
);
    logic signed [39:0] r_x, r_y;
    logic signed [17:0] r_z;
    logic signed [39:0] n_x, n_y;
    logic signed [17:0] n_z;

    always_comb begin
        n_x = i_x; n_y = i_y; n_z = i_z;
        if (i_on) begin
            if (i_y > 0) begin
                n_x = i_x + (i_y >>> STAGE);
                n_y = i_y - (i_x >>> STAGE);
                n_z = i_z + atan_bam(STAGE);
            end else begin
                n_x = i_x - (i_y >>> STAGE);
                n_y = i_y + (i_x >>> STAGE);
                n_z = i_z - atan_bam(STAGE);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x; r_y <= n_y; r_z <= n_z;
    end
    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
endmodule

/* rtl/core/odbc_rot_cell.sv */
// One rotation CORDIC cell for three wheel sines at once, registered.
`timescale 1ns / 1ps
module odbc_rot_cell
    import odbc_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  logic               i_clk,
    input  logic signed [33:0] i_x [3],
    input  logic signed [33:0] i_y [3],
    input  logic signed [17:0] i_z [3],
    output logic signed [33:0] o_x [3],
    output logic signed [33:0] o_y [3],
    output logic signed [17:0] o_z [3]
);
    logic signed [33:0] r_x [3], r_y [3];
    logic signed [17:0] r_z [3];

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            if (i_z[k] >= 0) begin
                r_x[k] <= i_x[k] - (i_y[k] >>> STAGE);
                r_y[k] <= i_y[k] + (i_x[k] >>> STAGE);
                r_z[k] <= i_z[k] - atan_bam(STAGE);
            end else begin
                r_x[k] <= i_x[k] + (i_y[k] >>> STAGE);
                r_y[k] <= i_y[k] - (i_x[k] >>> STAGE);
                r_z[k] <= i_z[k] + atan_bam(STAGE);
            end
        end
    end
    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;
endmodule

/* tb/tb_omni_drive_ball_chase_mixer.sv */
// Self-checking testbench for the omni drive ball chase mixer.
`timescale 1ns / 1ps
module tb_omni_drive_ball_chase_mixer;
    import odbc_pkg::*;

    // Pipeline depth of the block with default parameters, in cycles.
    localparam int LATENCY     = 2 * 16 + 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int N_RANDOM    = 600;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    t_in        i_data = '0;
    logic       o_done;
    t_out       o_data;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = '0;
    logic [9:0] i_cfg_data = '0;

    always #5 i_clk = ~i_clk;

    omni_drive_ball_chase_mixer u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_data    (i_data),
        .o_done    (o_done),
        .o_data    (o_data),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    // Shadow copies of the configuration registers, as the block should hold them.
    logic [9:0] thr_sh;
    logic [8:0] goal_sh;
    logic [7:0] power_sh;

    t_out motor_q[$];
    int   errors = 0;
    int   beats_in = 0;
    int   beats_out = 0;
    int   escapes = 0;
    int   cycles = 0;
    int   idle_pct = 0;
    int   stall_pct = 0;

    // Arctangent table in binary angle units, one entry per CORDIC stage.
    function automatic longint atan_step(input int i);
        longint t[16] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                          41, 20, 10, 5, 3, 1, 1, 0};
        return t[i];
    endfunction

    // Arithmetic shift right rounding toward minus infinity.
    function automatic longint asr(input longint v, input int s);
        return v >>> s;
    endfunction

    function automatic logic [15:0] ball_angle(input longint x, input longint y);
        longint z, dx, dy;
        z = 0;
        if (x == 0 && y == 0) return 16'd0;
        x = x * 256;
        y = y * 256;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32768;
        end
        for (int i = 0; i < 16; i++) begin
            dx = asr(y, i);
            dy = asr(x, i);
            if (y > 0) begin
                x += dx; y -= dy; z += atan_step(i);
            end else begin
                x -= dx; y += dy; z -= atan_step(i);
            end
        end
        return z[15:0];
    endfunction

    // Sine in Q1.14 by a gain-compensated CORDIC rotation, folded into +-90 degrees.
    function automatic longint sine14(input logic [15:0] phi);
        longint x, y, z, dx, dy, r;
        bit flip;
        x = 652032874;
        y = 0;
        flip = 0;
        if (phi >= 16384 && phi < 49152) begin
            phi = phi - 16'd32768;
            flip = 1;
        end
        z = (phi >= 32768) ? longint'(phi) - 65536 : longint'(phi);
        for (int i = 0; i < 16; i++) begin
            dx = asr(y, i);
            dy = asr(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_step(i);
            end else begin
                x += dx; y -= dy; z += atan_step(i);
            end
        end
        r = asr(y + 32768, 16);
        if (r > Q14_ONE) r = Q14_ONE;
        if (r < -Q14_ONE) r = -Q14_ONE;
        return flip ? -r : r;
    endfunction

    function automatic void wheel_drive(input logic [15:0] ang, input logic [15:0] offs,
                                        input longint rot, output logic [7:0] spd,
                                        output logic rev);
        longint s, mag;
        s = sine14(ang - offs) + rot;
        if (s > Q14_ONE) s = Q14_ONE;
        if (s < -Q14_ONE) s = -Q14_ONE;
        mag = (s < 0) ? -s : s;
        spd = 8'((longint'(power_sh) * mag) >>> 14);
        rev = (s < 0 && power_sh != 0);
    endfunction

    function automatic t_out mix_motors(input t_in f);
        t_out   o;
        longint x, y, diff, rot;
        longint rd[8];
        longint wc[8] = '{0, 11585, 16384, 11585, 0, -11585, -16384, -11585};
        longint ws[8] = '{16384, 11585, 0, -11585, -16384, -11585, 0, 11585};
        logic [15:0] ang;
        o = '0;
        if (f.line_one > thr_sh) begin
            o.wheel_a_speed = ESCAPE_SPEED; o.wheel_b_speed = ESCAPE_SPEED;
            o.wheel_b_reverse = 1'b1; o.drive_mode = MODE_LINE1;
            return o;
        end
        if (f.line_two > thr_sh) begin
            o.wheel_b_speed = ESCAPE_SPEED; o.wheel_c_speed = ESCAPE_SPEED;
            o.wheel_c_reverse = 1'b1; o.drive_mode = MODE_LINE2;
            return o;
        end
        if (f.line_three > thr_sh) begin
            o.wheel_a_speed = ESCAPE_SPEED; o.wheel_a_reverse = 1'b1;
            o.wheel_c_speed = ESCAPE_SPEED; o.drive_mode = MODE_LINE3;
            return o;
        end
        rd = '{f.ball_front, f.ball_front_right, f.ball_right, f.ball_back_right,
               f.ball_back, f.ball_back_left, f.ball_left, f.ball_front_left};
        x = 0;
        y = 0;
        for (int i = 0; i < 8; i++) begin
            x += rd[i] * wc[i];
            y += rd[i] * ws[i];
        end
        ang = ball_angle(x, y);
        diff = longint'(f.heading) - longint'(goal_sh);
        if (diff > 180) diff -= 360;
        else if (diff < -180) diff += 360;
        rot = (diff * Q14_ONE) / 180;
        wheel_drive(ang, OFFSET_A, rot, o.wheel_a_speed, o.wheel_a_reverse);
        wheel_drive(ang, OFFSET_B, rot, o.wheel_b_speed, o.wheel_b_reverse);
        wheel_drive(ang, OFFSET_C, rot, o.wheel_c_speed, o.wheel_c_reverse);
        o.drive_mode = MODE_CHASE;
        return o;
    endfunction

    // Every accepted sensor frame is predicted at the edge that accepts it.
    // Results are compared at the edge that ends their strobe cycle.
    always @(posedge i_clk) begin
        t_out want;
        cycles <= cycles + 1;
        if (i_rst_n && start && !busy) begin
            motor_q.push_back(mix_motors(i_data));
            beats_in <= beats_in + 1;
        end
        if (i_rst_n && o_done) begin
            beats_out <= beats_out + 1;
            if (o_data.drive_mode != MODE_CHASE) escapes <= escapes + 1;
            if (motor_q.size() == 0) begin
                $display("%0t: result beat with nothing expected: actual %p", $time, o_data);
                errors <= errors + 1;
            end else begin
                want = motor_q.pop_front();
                if (o_data !== want) begin
                    $display("%0t: mismatch expected %p actual %p", $time, want, o_data);
                    errors <= errors + 1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, motor_q.size());
            $display("FAILURE");
            $finish;
        end
    end

    task automatic write_reg(input t_reg idx, input logic [9:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_LINE_THRESHOLD: thr_sh = val;
            REG_GOAL_HEADING:   goal_sh = val[8:0];
            REG_MOTOR_POWER:    power_sh = val[7:0];
            default: ;
        endcase
    endtask

    // Present one frame for a beat, starting at a rising edge. Start stays high
    // into the next frame unless the sender first idles a random number of cycles.
    task automatic send_frame(input t_in f);
        while (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_data <= f;
        do @(posedge i_clk); while (busy);
    endtask

    // Wait for the pipeline to drain before touching configuration.
    task automatic drain();
        int guard;
        guard = 0;
        start <= 1'b0;
        while (motor_q.size() != 0 && guard < 20 * LATENCY) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (LATENCY) @(posedge i_clk);
    endtask

    function automatic t_in rand_frame(input int style);
        t_in f;
        f = t_in'({$urandom, $urandom, $urandom, $urandom});
        if (f.heading > 359 && $urandom_range(3, 0) != 0) f.heading = 9'($urandom_range(359, 0));
        // Mostly chase frames: keep every line reading at or under the threshold.
        if (style != 0) begin
            f.line_one   = 10'($urandom_range(thr_sh, 0));
            f.line_two   = 10'($urandom_range(thr_sh, 0));
            f.line_three = 10'($urandom_range(thr_sh, 0));
            if (style == 2) begin
                // Weak ball readings; front and back left each get a random value ORed in half the time.
                f.ball_front = 10'($urandom_range(60, 0));
                f.ball_front_right = 10'($urandom_range(60, 0));
                f.ball_right = 10'($urandom_range(60, 0));
                f.ball_back_right = 10'($urandom_range(60, 0));
                f.ball_back = 10'($urandom_range(60, 0));
                f.ball_back_left = 10'($urandom_range(60, 0));
                f.ball_left = 10'($urandom_range(60, 0));
                f.ball_front_left = 10'($urandom_range(60, 0));
                f.ball_front = f.ball_front | 10'($urandom_range(1023, 0) * ($urandom % 2));
                f.ball_back_left = f.ball_back_left | 10'($urandom_range(1023, 0) * ($urandom % 2));
            end
        end
        return f;
    endfunction

    // Directed rows: frame and, where it is plain, the expected result.
    typedef struct {
        t_in  f;
        bit   known;
        t_out o;
    } t_row;

    initial begin
        t_row rows[$];
        t_row r;
        t_out exp_o;
        thr_sh = 10'd650;
        goal_sh = 9'd0;
        power_sh = 8'd100;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Escape patterns, by priority of the line sensors.
        r.f = '0; r.f.line_one = 10'd1023; r.f.line_two = 10'd1023; r.known = 1;
        r.o = '{8'd100, 1'b0, 8'd100, 1'b1, 8'd0, 1'b0, MODE_LINE1};
        rows.push_back(r);
        r.f = '0; r.f.line_two = 10'd651; r.f.line_three = 10'd1023;
        r.o = '{8'd0, 1'b0, 8'd100, 1'b0, 8'd100, 1'b1, MODE_LINE2};
        rows.push_back(r);
        r.f = '1; r.f.line_one = 10'd650; r.f.line_two = 10'd650; r.f.line_three = 10'd651;
        r.o = '{8'd100, 1'b1, 8'd0, 1'b0, 8'd100, 1'b0, MODE_LINE3};
        rows.push_back(r);
        // Zero ball vector, heading on goal: the angle is 0.
        r.f = '0; r.known = 0;
        rows.push_back(r);
        // All sensors equal also cancel out to a zero vector.
        r.f = '0;
        r.f.ball_front = '1; r.f.ball_front_right = '1; r.f.ball_right = '1;
        r.f.ball_back_right = '1; r.f.ball_back = '1; r.f.ball_back_left = '1;
        r.f.ball_left = '1; r.f.ball_front_left = '1;
        rows.push_back(r);
        // One sensor at full scale for each direction, plus extreme headings.
        for (int i = 0; i < 8; i++) begin
            r.f = '0;
            r.f[i * 10 + 48 -: 10] = 10'd1023;
            r.f.heading = (i % 2) ? 9'd359 : 9'd180;
            rows.push_back(r);
        end
        r.f = '0; r.f.ball_front = 10'd1; r.f.heading = 9'd181; rows.push_back(r);
        r.f = '0; r.f.ball_left = 10'd1; r.f.heading = 9'd511; rows.push_back(r);
        r.f = '0; r.f.ball_back = 10'd1023; r.f.heading = 9'd90; rows.push_back(r);

        foreach (rows[k]) begin
            if (rows[k].known) begin
                exp_o = mix_motors(rows[k].f);
                if (exp_o !== rows[k].o) begin
                    $display("%0t: directed row %0d expected %p actual %p", $time, k,
                             rows[k].o, exp_o);
                    errors++;
                end
            end
            send_frame(rows[k].f);
        end
        drain();

        // Configuration settings, extremes included, each followed by random traffic.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin
                    write_reg(REG_MOTOR_POWER, 10'd255); write_reg(REG_GOAL_HEADING, 10'd359);
                    write_reg(REG_LINE_THRESHOLD, 10'd1023);
                    idle_pct = 0;
                end
                1: begin
                    write_reg(REG_MOTOR_POWER, 10'd0); write_reg(REG_GOAL_HEADING, 10'd0);
                    write_reg(REG_LINE_THRESHOLD, 10'd0);
                    idle_pct = 50;
                end
                2: begin
                    write_reg(REG_MOTOR_POWER, 10'd1); write_reg(REG_GOAL_HEADING, 10'd180);
                    write_reg(REG_LINE_THRESHOLD, 10'd900);
                    idle_pct = 0;
                end
                3: begin
                    write_reg(REG_MOTOR_POWER, 10'($urandom_range(255, 0)));
                    write_reg(REG_GOAL_HEADING, 10'($urandom_range(511, 0)));
                    write_reg(REG_LINE_THRESHOLD, 10'($urandom_range(1023, 500)));
                    idle_pct = 30;
                end
                4: begin
                    // Writes to the unused index must be ignored.
                    write_reg(t_reg'(2'd3), 10'h3FF);
                    write_reg(REG_MOTOR_POWER, 10'd200); write_reg(REG_GOAL_HEADING, 10'd270);
                    write_reg(REG_LINE_THRESHOLD, 10'd800);
                    idle_pct = 50;
                end
                default: begin
                    write_reg(REG_MOTOR_POWER, 10'd100); write_reg(REG_GOAL_HEADING, 10'd0);
                    write_reg(REG_LINE_THRESHOLD, 10'd650);
                    idle_pct = 0;
                end
            endcase
            for (int n = 0; n < N_RANDOM / 6; n++)
                send_frame(rand_frame(($urandom_range(9, 0) == 0) ? 0 :
                                      $urandom_range(2, 1)));
            idle_pct = 0;
            drain();
        end

        $display("Sent %0d sensor frames over six register settings; %0d result beats,",
                 beats_in, beats_out);
        $display("%0d of them line escapes, the rest ball chase mixes.", escapes);
        if (errors == 0 && motor_q.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d errors, %0d results never arrived", errors, motor_q.size());
            $display("FAILURE");
        end
        $finish;
    end
endmodule
